@@ rtl/core/grid_tile_nearest_scale_address_macros.svh @@
// Assertion helpers for the core module that includes them.
`ifndef GRID_TILE_NEAREST_SCALE_ADDRESS_MACROS_SVH
`define GRID_TILE_NEAREST_SCALE_ADDRESS_MACROS_SVH

// Same-cycle implication, sampled on the core clock, off during reset.
`define GTNSA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the core clock, off during reset.
`define GTNSA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/gtnsa_pkg.sv @@
package gtnsa_pkg;

   localparam int MAX_TILES     = 64;
   localparam int MAX_DIMENSION = 4096;

   localparam int DIM_W  = 13;
   localparam int POS_W  = 12;
   localparam int FC_W   = 7;
   localparam int TILE_W = 6;
   localparam int GRID_W = 4;

   // long divider: 25-bit dividend, 13-bit divisor, 14 quotient bits
   localparam int DIV_NUM_W  = 25;
   localparam int DIV_Q_W    = 14;
   localparam int DIV_BPS    = 2;
   localparam int DIV_STAGES = DIV_Q_W / DIV_BPS;

   localparam logic [1:0] ADDR_OUT_WIDTH   = 2'd0;
   localparam logic [1:0] ADDR_OUT_HEIGHT  = 2'd1;
   localparam logic [1:0] ADDR_FRAME_COUNT = 2'd2;

   function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : v;
   endfunction

   // smallest c with c*c >= count
   function automatic logic [GRID_W-1:0] cols_of(logic [FC_W-1:0] count);
      logic [GRID_W-1:0] c;
      if (count <= 7'd1) c = 4'd1;
      else if (count <= 7'd4) c = 4'd2;
      else if (count <= 7'd9) c = 4'd3;
      else if (count <= 7'd16) c = 4'd4;
      else if (count <= 7'd25) c = 4'd5;
      else if (count <= 7'd36) c = 4'd6;
      else if (count <= 7'd49) c = 4'd7;
      else c = 4'd8;
      return c;
   endfunction

   // compare-and-subtract division of a small value by a grid dimension,
   // good while the quotient stays below 16: returns {quotient, remainder}
   function automatic logic [7:0] grid_divmod(logic [7:0] n, logic [GRID_W-1:0] d);
      logic [7:0] r;
      logic [7:0] dd;
      logic [3:0] q;
      r = n;
      q = '0;
      for (int k = 3; k >= 0; k--) begin
         dd = {4'd0, d} << k;
         if (r >= dd) begin
            r    = r - dd;
            q[k] = 1'b1;
         end
      end
      return {q, r[3:0]};
   endfunction

   function automatic logic [GRID_W-1:0] rows_of(logic [FC_W-1:0] count,
                                                 logic [GRID_W-1:0] cols);
      logic [7:0] n;
      logic [7:0] dm;
      n  = {1'b0, count} + {4'd0, cols} - 8'd1;
      dm = grid_divmod(n, cols);
      return dm[7:4];
   endfunction

   function automatic logic [2:0] tile_col(logic [TILE_W-1:0] t, logic [GRID_W-1:0] cols);
      logic [7:0] dm;
      dm = grid_divmod({2'd0, t}, cols);
      return dm[2:0];
   endfunction

   function automatic logic [2:0] tile_row(logic [TILE_W-1:0] t, logic [GRID_W-1:0] cols);
      logic [7:0] dm;
      dm = grid_divmod({2'd0, t}, cols);
      return dm[6:4];
   endfunction

endpackage

@@ rtl/core/gtnsa_div.sv @@
module gtnsa_div (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [gtnsa_pkg::DIV_NUM_W-1:0]   num,
   input  logic [gtnsa_pkg::DIM_W-1:0]       den,
   output logic [gtnsa_pkg::DIV_Q_W-1:0]     quo
);
   import gtnsa_pkg::*;

   logic [DIM_W-1:0]   rem_ff  [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_ff [DIV_STAGES];
   logic [DIV_Q_W-1:0] quo_ff  [DIV_STAGES];
   logic [DIM_W-1:0]   den_ff  [DIV_STAGES];

   logic [DIM_W-1:0]   rem_in  [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_in [DIV_STAGES];
   logic [DIV_Q_W-1:0] quo_in  [DIV_STAGES];
   logic [DIM_W-1:0]   den_in  [DIV_STAGES];

   logic [DIM_W-1:0]   rem_src  [DIV_STAGES];
   logic [DIV_Q_W-1:0] bits_src [DIV_STAGES];
   logic [DIV_Q_W-1:0] quo_src  [DIV_STAGES];
   logic [DIM_W-1:0]   den_src  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign rem_src[s]  = DIM_W'(num[DIV_NUM_W-1:DIV_Q_W]);
         assign bits_src[s] = num[DIV_Q_W-1:0];
         assign quo_src[s]  = '0;
         assign den_src[s]  = den;
      end else begin : g_body
         assign rem_src[s]  = rem_ff[s-1];
         assign bits_src[s] = bits_ff[s-1];
         assign quo_src[s]  = quo_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
      end

      always_comb begin
         logic [DIM_W-1:0]   r;
         logic [DIV_Q_W-1:0] b;
         logic [DIV_Q_W-1:0] q;
         logic [DIM_W-1:0]   d;
         logic [DIM_W:0]     r2;
         r = rem_src[s];
         b = bits_src[s];
         q = quo_src[s];
         d = den_src[s];
         // restoring steps, one quotient bit each
         for (int k = 0; k < DIV_BPS; k++) begin
            r2 = {r, b[DIV_Q_W-1]};
            b  = {b[DIV_Q_W-2:0], 1'b0};
            if (r2 >= {1'b0, d}) begin
               r = DIM_W'(r2 - {1'b0, d});
               q = {q[DIV_Q_W-2:0], 1'b1};
            end else begin
               r = r2[DIM_W-1:0];
               q = {q[DIV_Q_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = r;
         bits_in[s] = b;
         quo_in[s]  = q;
         den_in[s]  = d;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            quo_ff[s]  <= quo_in[s];
            den_ff[s]  <= den_in[s];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

@@ rtl/core/grid_tile_nearest_scale_address.sv @@
// Channel  | direction | handshake             | payload
// req_     | in        | req_valid/req_ready   | tile, plane, local pos, source size, flag
// rsp_     | out       | rsp_valid/rsp_ready   | dest pos, source pos, in_tile, tile size
// csr_     | in        | psel/penable, pready  | out_width, out_height, frame_count
//
// One request per cycle while responses are taken; path: stage 1, then the two seven-stage
// long dividers (tile bounds, then nearest-neighbor scaling) split by stage 2, then output.
// Reset is synchronous, active high; it clears valid bits and loads register defaults.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
module grid_tile_nearest_scale_address (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_tile_index,
   input  logic        req_chroma_plane,
   input  logic [11:0] req_local_x,
   input  logic [11:0] req_local_y,
   input  logic [12:0] req_src_width,
   input  logic [12:0] req_src_height,
   input  logic        req_frame_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_dest_x,
   output logic [11:0] rsp_dest_y,
   output logic [11:0] rsp_source_x,
   output logic [11:0] rsp_source_y,
   output logic        rsp_in_tile,
   output logic [12:0] rsp_tile_plane_width,
   output logic [12:0] rsp_tile_plane_height,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gtnsa_pkg::*;

`include "grid_tile_nearest_scale_address_macros.svh"

   typedef struct packed {
      logic             chroma;
      logic [POS_W-1:0] lx;
      logic [POS_W-1:0] ly;
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic             fv;
      logic             in_range;
   } side1_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] dx;
      logic [POS_W-1:0] dy;
      logic [DIM_W-1:0] tw;
      logic [DIM_W-1:0] th;
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
   } side2_type;

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0] out_width_ff, out_height_ff;
   logic [FC_W-1:0]  frame_count_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff   <= DIM_W'(1920);
         out_height_ff  <= DIM_W'(1080);
         frame_count_ff <= FC_W'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            ADDR_OUT_WIDTH:   out_width_ff   <= csr_pwdata[DIM_W-1:0];
            ADDR_OUT_HEIGHT:  out_height_ff  <= csr_pwdata[DIM_W-1:0];
            ADDR_FRAME_COUNT: frame_count_ff <= csr_pwdata[FC_W-1:0];
            default: ;  // unmapped: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ADDR_OUT_WIDTH:   csr_prdata = {19'd0, out_width_ff};
         ADDR_OUT_HEIGHT:  csr_prdata = {19'd0, out_height_ff};
         ADDR_FRAME_COUNT: csr_prdata = {25'd0, frame_count_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Grid shape follows the registers only; the user must change them only while idle (not enforced).
   logic [DIM_W-1:0]  ow, oh;
   logic [FC_W-1:0]   fc_sat, count;
   logic [GRID_W-1:0] cols, rows;

   assign ow     = sat_dim(out_width_ff);
   assign oh     = sat_dim(out_height_ff);
   assign fc_sat = (frame_count_ff > FC_W'(MAX_TILES)) ? FC_W'(MAX_TILES) : frame_count_ff;
   assign count  = (fc_sat == '0) ? FC_W'(1) : fc_sat;
   assign cols   = cols_of(count);
   assign rows   = rows_of(count, cols);

   // Whole pipeline moves together; hold everything while the result waits.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------- stage 1: tile position, bound numerators ----------------
   logic [2:0]  col, row;
   logic [15:0] nx0_in, nx1_in, ny0_in, ny1_in;
   side1_type   s1_in;

   assign col    = tile_col(req_tile_index, cols);
   assign row    = tile_row(req_tile_index, cols);
   assign nx0_in = {13'd0, col} * {3'd0, ow};
   assign nx1_in = ({13'd0, col} + 16'd1) * {3'd0, ow};
   assign ny0_in = {13'd0, row} * {3'd0, oh};
   assign ny1_in = ({13'd0, row} + 16'd1) * {3'd0, oh};

   always_comb begin
      s1_in.chroma   = req_chroma_plane;
      s1_in.lx       = req_local_x;
      s1_in.ly       = req_local_y;
      s1_in.sw       = sat_dim(req_src_width);
      s1_in.sh       = sat_dim(req_src_height);
      s1_in.fv       = req_frame_valid;
      s1_in.in_range = {1'b0, req_tile_index} < fc_sat;
   end

   logic              s1_valid_ff;
   side1_type         s1_ff;
   logic [15:0]       nx0_ff, nx1_ff, ny0_ff, ny1_ff;
   logic [GRID_W-1:0] cols_ff, rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff   <= s1_in;
         nx0_ff  <= nx0_in;
         nx1_ff  <= nx1_in;
         ny0_ff  <= ny0_in;
         ny1_ff  <= ny1_in;
         cols_ff <= cols;
         rows_ff <= rows;
      end
   end

   // ---------------- divider bank 1: tile rectangle edges ----------------
   logic [DIV_Q_W-1:0] x0_q, x1_q, y0_q, y1_q;

   gtnsa_div u_div_x0 (.clock(clock), .advance(advance), .num(DIV_NUM_W'(nx0_ff)),
      .den(DIM_W'(cols_ff)), .quo(x0_q));
   gtnsa_div u_div_x1 (.clock(clock), .advance(advance), .num(DIV_NUM_W'(nx1_ff)),
      .den(DIM_W'(cols_ff)), .quo(x1_q));
   gtnsa_div u_div_y0 (.clock(clock), .advance(advance), .num(DIV_NUM_W'(ny0_ff)),
      .den(DIM_W'(rows_ff)), .quo(y0_q));
   gtnsa_div u_div_y1 (.clock(clock), .advance(advance), .num(DIV_NUM_W'(ny1_ff)),
      .den(DIM_W'(rows_ff)), .quo(y1_q));

   // Side data rides alongside the divider stages.
   logic      d1_valid_ff [DIV_STAGES];
   side1_type d1_ff       [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) d1_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         d1_valid_ff[0] <= s1_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) d1_valid_ff[i] <= d1_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff[0] <= s1_ff;
         for (int i = 1; i < DIV_STAGES; i++) d1_ff[i] <= d1_ff[i-1];
      end
   end

   // ---------------- stage 2: plane sizing, destination, scale numerators ----------------
   side1_type        e1;
   logic [DIM_W-1:0] x0, x1, y0, y1, sw_p, sh_p;
   side2_type        s2_in;
   logic [24:0]      numx_in, numy_in;

   assign e1 = d1_ff[DIV_STAGES-1];

   always_comb begin
      if (e1.chroma) begin
         x0   = DIM_W'(x0_q >> 1);
         y0   = DIM_W'(y0_q >> 1);
         x1   = DIM_W'((x1_q + DIV_Q_W'(1)) >> 1);
         y1   = DIM_W'((y1_q + DIV_Q_W'(1)) >> 1);
         sw_p = DIM_W'(({1'b0, e1.sw} + 14'd1) >> 1);
         sh_p = DIM_W'(({1'b0, e1.sh} + 14'd1) >> 1);
      end else begin
         x0   = DIM_W'(x0_q);
         y0   = DIM_W'(y0_q);
         x1   = DIM_W'(x1_q);
         y1   = DIM_W'(y1_q);
         sw_p = e1.sw;
         sh_p = e1.sh;
      end
      s2_in.tw = (e1.in_range && x1 > x0) ? x1 - x0 : '0;
      s2_in.th = (e1.in_range && y1 > y0) ? y1 - y0 : '0;
      s2_in.hit = e1.in_range && e1.fv && (sw_p != '0) && (sh_p != '0)
                  && ({1'b0, e1.lx} < s2_in.tw) && ({1'b0, e1.ly} < s2_in.th);
      s2_in.dx = POS_W'(x0 + {1'b0, e1.lx});
      s2_in.dy = POS_W'(y0 + {1'b0, e1.ly});
      s2_in.sw = sw_p;
      s2_in.sh = sh_p;
      numx_in  = {13'd0, e1.lx} * {12'd0, sw_p};
      numy_in  = {13'd0, e1.ly} * {12'd0, sh_p};
   end

   logic        s2_valid_ff;
   side2_type   s2_ff;
   logic [24:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= d1_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff   <= s2_in;
         numx_ff <= numx_in;
         numy_ff <= numy_in;
      end
   end

   // ---------------- divider bank 2: nearest source position ----------------
   logic [DIV_Q_W-1:0] sx_q, sy_q;

   gtnsa_div u_div_sx (.clock(clock), .advance(advance), .num(numx_ff),
      .den(s2_ff.tw), .quo(sx_q));
   gtnsa_div u_div_sy (.clock(clock), .advance(advance), .num(numy_ff),
      .den(s2_ff.th), .quo(sy_q));

   logic      d2_valid_ff [DIV_STAGES];
   side2_type d2_ff       [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) d2_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         d2_valid_ff[0] <= s2_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) d2_valid_ff[i] <= d2_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_ff[0] <= s2_ff;
         for (int i = 1; i < DIV_STAGES; i++) d2_ff[i] <= d2_ff[i-1];
      end
   end

   // ---------------- output stage: clamp, zero outside the tile ----------------
   side2_type          e2;
   logic [DIV_Q_W-1:0] swm1, shm1;
   logic [POS_W-1:0]   dest_x_in, dest_y_in, source_x_in, source_y_in;

   assign e2   = d2_ff[DIV_STAGES-1];
   assign swm1 = {1'b0, e2.sw} - DIV_Q_W'(1);
   assign shm1 = {1'b0, e2.sh} - DIV_Q_W'(1);

   always_comb begin
      if (e2.hit) begin
         dest_x_in   = e2.dx;
         dest_y_in   = e2.dy;
         source_x_in = POS_W'((sx_q > swm1) ? swm1 : sx_q);
         source_y_in = POS_W'((sy_q > shm1) ? shm1 : sy_q);
      end else begin
         dest_x_in   = '0;
         dest_y_in   = '0;
         source_x_in = '0;
         source_y_in = '0;
      end
   end

   logic [POS_W-1:0] dest_x_ff, dest_y_ff, source_x_ff, source_y_ff;
   logic             in_tile_ff;
   logic [DIM_W-1:0] tpw_ff, tph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d2_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dest_x_ff   <= dest_x_in;
         dest_y_ff   <= dest_y_in;
         source_x_ff <= source_x_in;
         source_y_ff <= source_y_in;
         in_tile_ff  <= e2.hit;
         tpw_ff      <= e2.tw;
         tph_ff      <= e2.th;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dest_x            = dest_x_ff;
   assign rsp_dest_y            = dest_y_ff;
   assign rsp_source_x          = source_x_ff;
   assign rsp_source_y          = source_y_ff;
   assign rsp_in_tile           = in_tile_ff;
   assign rsp_tile_plane_width  = tpw_ff;
   assign rsp_tile_plane_height = tph_ff;

   // ---------------- checks ----------------
   `GTNSA_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, s1_valid_ff)
   `GTNSA_ASSERT_NOW(a_in_tile_sized, rsp_valid && rsp_in_tile,
      rsp_tile_plane_width != '0 && rsp_tile_plane_height != '0)
   `GTNSA_ASSERT_NOW(a_outside_zero, rsp_valid && !rsp_in_tile,
      rsp_dest_x == '0 && rsp_source_x == '0 && rsp_dest_y == '0 && rsp_source_y == '0)

endmodule
